FILE: src/lru_pkg.sv
package lru_pkg;

   // Field widths fixed by the interface definition
   localparam int CFG_W         = 5;
   localparam int FRAME_INDEX_W = 4;
   localparam int FAULT_W       = 16;

   localparam logic [CFG_W-1:0]   CFG_RESET = 5'd3;
   localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

   // Write command to the frame store
   typedef struct packed {
      logic wr_en;       // write the stamp of the chosen frame
      logic wr_page_en;  // also load a new page and mark the frame valid
      logic clear;       // drop every valid mark after this write
   } store_ctl_type;

   // Control of the shared compare unit
   typedef struct packed {
      logic clear;       // start of a new request
      logic en;          // read data at the unit's inputs is live
   } scan_ctl_type;

endpackage

FILE: src/lru_req_if.sv
interface lru_req_if #(
   parameter int PAGE_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page;
   logic                 end_of_string;

   modport source (output valid, output page, output end_of_string, input ready);
   modport sink   (input valid, input page, input end_of_string, output ready);
endinterface

FILE: src/lru_rsp_if.sv
interface lru_rsp_if #(
   parameter int PAGE_BITS = 16
);
   import lru_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic [FRAME_INDEX_W-1:0] frame_index;
   logic                     evicted_valid;
   logic [PAGE_BITS-1:0]     evicted_page;
   logic [FAULT_W-1:0]       fault_count;
   logic                     last;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output fault_count, output last, input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, input fault_count, input last, output ready);
endinterface

FILE: src/lru_csr_if.sv
interface lru_csr_if;
   import lru_pkg::*;

   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/lru_frame_store.sv
module lru_frame_store #(
   parameter int FRAMES     = 16,
   parameter int PAGE_BITS  = 16,
   parameter int STAMP_BITS = 32,
   parameter int IDX_W      = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lru_pkg::store_ctl_type ctl,
   input  logic [IDX_W-1:0]       wr_idx,
   input  logic [PAGE_BITS-1:0]   wr_page,
   input  logic [STAMP_BITS-1:0]  wr_stamp,
   input  logic [IDX_W-1:0]       rd_addr,
   output logic [PAGE_BITS-1:0]   rd_page,
   output logic [STAMP_BITS-1:0]  rd_stamp,
   output logic                   rd_valid
);
   import lru_pkg::*;

   logic [PAGE_BITS-1:0]  page_mem  [FRAMES];
   logic [STAMP_BITS-1:0] stamp_mem [FRAMES];
   logic [FRAMES-1:0]     valid_ff;
   logic [FRAMES-1:0]     valid_in;
   logic [PAGE_BITS-1:0]  rd_page_ff;
   logic [STAMP_BITS-1:0] rd_stamp_ff;
   logic                  rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_page_en) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (ctl.clear) begin
         valid_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         stamp_mem[wr_idx] <= wr_stamp;
      end
      if (ctl.wr_page_en) begin
         page_mem[wr_idx] <= wr_page;
      end
      rd_page_ff  <= page_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_page  = rd_page_ff;
   assign rd_stamp = rd_stamp_ff;
   assign rd_valid = rd_valid_ff;

endmodule

FILE: src/lru_scan_unit.sv
module lru_scan_unit #(
   parameter int PAGE_BITS  = 16,
   parameter int STAMP_BITS = 32,
   parameter int IDX_W      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lru_pkg::scan_ctl_type ctl,
   input  logic [IDX_W-1:0]      idx,
   input  logic [PAGE_BITS-1:0]  ref_page,
   input  logic [PAGE_BITS-1:0]  rd_page,
   input  logic [STAMP_BITS-1:0] rd_stamp,
   input  logic                  rd_valid,
   output logic                  hit,
   output logic [IDX_W-1:0]      hit_idx,
   output logic [IDX_W-1:0]      min_idx,
   output logic [PAGE_BITS-1:0]  min_page
);
   import lru_pkg::*;

   logic                  hit_ff;
   logic [IDX_W-1:0]      hit_idx_ff;
   logic [STAMP_BITS-1:0] min_stamp_ff;
   logic [IDX_W-1:0]      min_idx_ff;
   logic [PAGE_BITS-1:0]  min_page_ff;
   logic                  match;
   logic                  older;

   // First match wins; strict compare keeps the lowest index on equal stamps
   assign match = ctl.en && !hit_ff && rd_valid && (rd_page == ref_page);
   assign older = ctl.en && ((idx == '0) || (rd_stamp < min_stamp_ff));

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         hit_ff <= 1'b0;
      end else if (match) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (match) begin
         hit_idx_ff <= idx;
      end
      if (older) begin
         min_stamp_ff <= rd_stamp;
         min_idx_ff   <= idx;
         min_page_ff  <= rd_page;
      end
   end

   assign hit      = hit_ff;
   assign hit_idx  = hit_idx_ff;
   assign min_idx  = min_idx_ff;
   assign min_page = min_page_ff;

endmodule

FILE: src/lru_page_replacement.sv
// Channel   Dir  Handshake     Payload
// req_ch    in   valid/ready   page, end_of_string
// rsp_ch    out  valid/ready   hit, frame_index, evicted_valid, evicted_page,
//                              fault_count, last
// csr_ch    in   valid/ready   data (frames_in_use)
//
// After the accepting edge the effective frames (1..FRAMES) are read in ST_SCAN
// through the single read port of the frame store; ST_DRAIN drains the last
// compare and ST_FINISH writes back and registers the response. req_ch is
// ready only while idle, so a request is taken only once the last is written
// back. A pending response does not block acceptance; write-back waits for
// the output register to free. Synchronous reset clears all valid marks at once.
module lru_page_replacement #(
   parameter int FRAMES     = 16,
   parameter int PAGE_BITS  = 16,
   parameter int STAMP_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   lru_req_if.sink  req_ch,
   lru_rsp_if.source rsp_ch,
   lru_csr_if.sink  csr_ch
);
   import lru_pkg::*;

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [CFG_W-1:0]      cfg_ff, cfg_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic                  cmp_en_ff, cmp_en_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic                  last_ff, last_in;
   logic [CNT_W-1:0]      filled_ff, filled_in;
   logic [STAMP_BITS-1:0] counter_ff, counter_in;
   logic [FAULT_W-1:0]    faults_ff, faults_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic [FRAME_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic                     rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [PAGE_BITS-1:0]     rsp_ev_page_ff, rsp_ev_page_in;
   logic [FAULT_W-1:0]       rsp_faults_ff, rsp_faults_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [CMP_W-1:0]      cfg_wide;
   logic [CMP_W-1:0]      n_wide;
   logic                  req_fire;
   logic                  finish_fire;
   logic                  fill;
   logic [IDX_W-1:0]      slot;
   logic [IDX_W+FRAME_INDEX_W-1:0] slot_wide;
   logic [STAMP_BITS-1:0] stamp_next;

   store_ctl_type         store_ctl;
   scan_ctl_type          scan_ctl;
   logic [PAGE_BITS-1:0]  rd_page;
   logic [STAMP_BITS-1:0] rd_stamp;
   logic                  rd_valid;
   logic                  scan_hit;
   logic [IDX_W-1:0]      scan_hit_idx;
   logic [IDX_W-1:0]      scan_min_idx;
   logic [PAGE_BITS-1:0]  scan_min_page;

   // Clamp the frame count register into 1..FRAMES
   assign cfg_wide = CMP_W'(cfg_ff);
   always_comb begin
      if (cfg_wide == '0) begin
         n_wide = CMP_W'(1);
      end else if (cfg_wide > CMP_W'(FRAMES)) begin
         n_wide = CMP_W'(FRAMES);
      end else begin
         n_wide = cfg_wide;
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign finish_fire  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   // Choose the frame: hit frame, next empty frame, or the oldest one
   assign fill = !scan_hit && (filled_ff < n_ff);
   always_comb begin
      if (scan_hit) begin
         slot = scan_hit_idx;
      end else if (fill) begin
         slot = filled_ff[IDX_W-1:0];
      end else begin
         slot = scan_min_idx;
      end
   end
   assign slot_wide  = {{FRAME_INDEX_W{1'b0}}, slot};
   assign stamp_next = counter_ff + STAMP_BITS'(1);

   always_comb begin
      state_in        = state_ff;
      cfg_in          = cfg_ff;
      n_in            = n_ff;
      addr_in         = addr_ff;
      cmp_en_in       = 1'b0;
      cmp_idx_in      = addr_ff;
      page_in         = page_ff;
      last_in         = last_ff;
      filled_in       = filled_ff;
      counter_in      = counter_ff;
      faults_in       = faults_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_page_in  = rsp_ev_page_ff;
      rsp_faults_in   = rsp_faults_ff;
      rsp_last_in     = rsp_last_ff;

      if (csr_ch.valid) begin
         cfg_in = csr_ch.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               page_in  = req_ch.page;
               last_in  = req_ch.end_of_string;
               n_in     = n_wide[CNT_W-1:0];
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one read per cycle; compare it the cycle after
            cmp_en_in = 1'b1;
            if (CNT_W'(addr_ff) + CNT_W'(1) == n_ff) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish_fire) begin
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = scan_hit;
               rsp_index_in    = slot_wide[FRAME_INDEX_W-1:0];
               rsp_ev_valid_in = !scan_hit && !fill;
               rsp_ev_page_in  = (!scan_hit && !fill) ? scan_min_page : '0;
               rsp_last_in     = last_ff;
               faults_in       = faults_ff;
               if (!scan_hit && (faults_ff != FAULT_MAX)) begin
                  faults_in = faults_ff + FAULT_W'(1);
               end
               rsp_faults_in = faults_in;
               counter_in    = stamp_next;
               if (fill) begin
                  filled_in = filled_ff + CNT_W'(1);
               end
               // End of string: drop the table and the counts
               if (last_ff) begin
                  counter_in = '0;
                  faults_in  = '0;
                  filled_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= CFG_RESET;
         cmp_en_ff    <= 1'b0;
         filled_ff    <= '0;
         counter_ff   <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         cmp_en_ff    <= cmp_en_in;
         filled_ff    <= filled_in;
         counter_ff   <= counter_in;
         faults_ff    <= faults_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff            <= n_in;
      addr_ff         <= addr_in;
      cmp_idx_ff      <= cmp_idx_in;
      page_ff         <= page_in;
      last_ff         <= last_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_page_ff  <= rsp_ev_page_in;
      rsp_faults_ff   <= rsp_faults_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // Write back the chosen frame; a fill or eviction also loads the page
   assign store_ctl.wr_en      = finish_fire;
   assign store_ctl.wr_page_en = finish_fire && !scan_hit;
   assign store_ctl.clear      = finish_fire && last_ff;

   assign scan_ctl.clear = req_fire;
   assign scan_ctl.en    = cmp_en_ff;

   lru_frame_store #(
      .FRAMES     (FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .STAMP_BITS (STAMP_BITS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (store_ctl),
      .wr_idx   (slot),
      .wr_page  (page_ff),
      .wr_stamp (stamp_next),
      .rd_addr  (addr_ff),
      .rd_page  (rd_page),
      .rd_stamp (rd_stamp),
      .rd_valid (rd_valid)
   );

   lru_scan_unit #(
      .PAGE_BITS  (PAGE_BITS),
      .STAMP_BITS (STAMP_BITS),
      .IDX_W      (IDX_W)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .idx      (cmp_idx_ff),
      .ref_page (page_ff),
      .rd_page  (rd_page),
      .rd_stamp (rd_stamp),
      .rd_valid (rd_valid),
      .hit      (scan_hit),
      .hit_idx  (scan_hit_idx),
      .min_idx  (scan_min_idx),
      .min_page (scan_min_page)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.hit           = rsp_hit_ff;
   assign rsp_ch.frame_index   = rsp_index_ff;
   assign rsp_ch.evicted_valid = rsp_ev_valid_ff;
   assign rsp_ch.evicted_page  = rsp_ev_page_ff;
   assign rsp_ch.fault_count   = rsp_faults_ff;
   assign rsp_ch.last          = rsp_last_ff;

endmodule

FILE: dv/tb_lru_page_replacement.sv
`timescale 1ns / 100ps

module tb_lru_page_replacement;
   import lru_pkg::*;

   localparam int FRAMES      = 16;
   localparam int PAGE_BITS   = 16;
   localparam int STAMP_BITS  = 32;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 150;
   // a short string of fresh pages through a single frame
   localparam int FRESH_ITEMS   = 40;

   // One response as the block presents it
   typedef struct packed {
      logic                     hit;
      logic [FRAME_INDEX_W-1:0] frame_index;
      logic                     evicted_valid;
      logic [PAGE_BITS-1:0]     evicted_page;
      logic [FAULT_W-1:0]       fault_count;
      logic                     last;
   } page_result_type;

   // Shadow of the frame table: predicts each response from the accepted
   // requests and checks the responses in order against that prediction.
   class lru_shadow;
      logic [PAGE_BITS-1:0]  pages [FRAMES];
      bit                    occupied [FRAMES];
      logic [STAMP_BITS-1:0] last_use [FRAMES];
      int unsigned           filled;
      logic [STAMP_BITS-1:0] use_count;
      logic [FAULT_W-1:0]    faults;
      logic [CFG_W-1:0]      frames_reg;
      page_result_type       expected_q [$];
      int unsigned           mismatches;

      function new();
         frames_reg = CFG_RESET;
         mismatches = 0;
         clear_string();
      endfunction

      function void clear_string();
         foreach (occupied[k]) occupied[k] = 1'b0;
         filled    = 0;
         use_count = '0;
         faults    = '0;
      endfunction

      function void write_frames(logic [CFG_W-1:0] value);
         frames_reg = value;
      endfunction

      // 0 behaves as one frame, anything beyond the build as all of them
      function int unsigned managed();
         if (frames_reg == 0) return 1;
         if (frames_reg > FRAMES) return FRAMES;
         return frames_reg;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [PAGE_BITS-1:0] page, logic eos);
         int unsigned     n;
         int unsigned     slot;
         bit              found;
         page_result_type r;
         n     = managed();
         slot  = 0;
         found = 1'b0;
         r     = '0;
         // only frames below the managed count take part in the search
         for (int k = 0; k < n; k++) begin
            if (!found && occupied[k] && pages[k] == page) begin
               found = 1'b1;
               slot  = k;
            end
         end
         use_count = use_count + 1'b1;
         if (!found) begin
            if (faults != FAULT_MAX) faults = faults + 1'b1;
            if (filled < n) begin
               slot   = filled;
               filled = filled + 1;
            end else begin
               // oldest stamp wins, strict compare keeps the lowest index on a tie
               for (int k = 1; k < n; k++) begin
                  if (last_use[k] < last_use[slot]) slot = k;
               end
               r.evicted_valid = 1'b1;
               r.evicted_page  = pages[slot];
            end
            pages[slot]    = page;
            occupied[slot] = 1'b1;
         end
         last_use[slot] = use_count;
         r.hit         = found;
         r.frame_index = FRAME_INDEX_W'(slot);
         r.fault_count = faults;
         r.last        = eos;
         expected_q.push_back(r);
         if (eos) clear_string();
      endfunction

      function void compare_field(string field, longint unsigned want, longint unsigned got);
         if (want != got) begin
            mismatches++;
            $display("%0t: mismatch on %s, expected %0h, actual %0h",
                     $time, field, want, got);
         end
      endfunction

      function void check_response(page_result_type got);
         page_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: response with none expected, expected nothing, actual %h",
                     $time, got);
            return;
         end
         want = expected_q.pop_front();
         compare_field("hit",           want.hit,           got.hit);
         compare_field("frame_index",   want.frame_index,   got.frame_index);
         compare_field("evicted_valid", want.evicted_valid, got.evicted_valid);
         compare_field("evicted_page",  want.evicted_page,  got.evicted_page);
         compare_field("fault_count",   want.fault_count,   got.fault_count);
         compare_field("last",          want.last,          got.last);
      endfunction
   endclass

   logic clock;
   logic reset;

   lru_req_if #(.PAGE_BITS(PAGE_BITS)) req_ch ();
   lru_rsp_if #(.PAGE_BITS(PAGE_BITS)) rsp_ch ();
   lru_csr_if                          csr_ch ();

   lru_page_replacement #(
      .FRAMES     (FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .STAMP_BITS (STAMP_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   lru_shadow shadow = new();

   // Shared between the request side and the response side
   bit quiet;       // no idling on either side while set
   bit hold_arm;    // request a long response hold-off
   bit hold_done;   // the hold-off has been served

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give every input a known value from time zero
   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.page          = '0;
      req_ch.end_of_string = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.data          = '0;
      rsp_ch.ready         = 1'b0;
      quiet                = 1'b0;
      hold_arm             = 1'b0;
      hold_done            = 1'b0;
   end

   // Watch all three handshakes on the edge. Check the response before
   // noting a request so a request taken on the same edge cannot match it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            shadow.check_response('{rsp_ch.hit, rsp_ch.frame_index, rsp_ch.evicted_valid,
                                    rsp_ch.evicted_page, rsp_ch.fault_count, rsp_ch.last});
         if (req_ch.valid && req_ch.ready)
            shadow.note_request(req_ch.page, req_ch.end_of_string);
         if (csr_ch.valid && csr_ch.ready)
            shadow.write_frames(csr_ch.data);
      end
   end

   // Response side: stall about 7 percent of the time, none while quiet, and once
   // hold off for a long stretch so the block backs up into the request side.
   initial begin : response_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_arm && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
         end else if (quiet) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 7);
         end
      end
   end

   // Abandon the run if it overstays the limit
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d responses outstanding", $time, shadow.pending());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Offer one request; idle first now and then, and hold until accepted.
   // Valid stays high between back-to-back requests.
   task automatic push_reference(logic [PAGE_BITS-1:0] page, logic eos);
      if (!quiet && $urandom_range(99) < 7) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.page          <= page;
      req_ch.end_of_string <= eos;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop offering and wait until every predicted response has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   // Write frames_in_use; only ever called with the block drained
   task automatic set_frames(logic [CFG_W-1:0] value);
      drain_results();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [PAGE_BITS-1:0] working_set [20];
      int unsigned          set_size;
      logic [CFG_W-1:0]     phase_cfg [RANDOM_PHASES];
      logic [PAGE_BITS-1:0] page;
      logic                 eos;

      phase_cfg = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd0, 5'd4, 5'd3};
      phase_cfg[5] = CFG_W'($urandom_range(31));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset value of three frames: fill, hit, evict the oldest, end the string
      push_reference(16'h0000, 1'b0);
      push_reference(16'hFFFF, 1'b0);
      push_reference(16'h0000, 1'b0);
      push_reference(16'hAAAA, 1'b0);
      push_reference(16'h5555, 1'b0);
      push_reference(16'hAAAA, 1'b1);

      // Zero acts as a single frame
      set_frames(5'd0);
      push_reference(16'h5555, 1'b0);
      push_reference(16'h5555, 1'b0);
      push_reference(16'h1234, 1'b0);

      // Above the build acts as all frames; filling resumes mid-string
      set_frames(5'd31);
      for (int k = 1; k <= 15; k++) push_reference(PAGE_BITS'(16'h0101 * k), 1'b0);
      push_reference(16'hC3C3, 1'b0);

      // Shrink mid-string: frames above the count drop out of the search
      set_frames(5'd2);
      push_reference(16'h0202, 1'b0);
      push_reference(16'hC3C3, 1'b1);

      // Grow mid-string with room left: filling carries on from where it was
      push_reference(16'h8001, 1'b0);
      push_reference(16'h7FFE, 1'b0);
      set_frames(5'd5);
      push_reference(16'h8001, 1'b0);
      push_reference(16'h4000, 1'b1);

      // One frame and a string of fresh pages: every request after the first
      // evicts the one before
      set_frames(5'd1);
      for (int i = 0; i < FRESH_ITEMS; i++)
         push_reference(PAGE_BITS'(i), (i == FRESH_ITEMS - 1));

      // Random strings over a small working set, with some stray pages
      set_size = 0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_frames(phase_cfg[p]);
         quiet = (p == 2);
         if (p == 4) hold_arm = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (set_size == 0) begin
               set_size = $urandom_range(1, 20);
               for (int k = 0; k < set_size; k++)
                  working_set[k] = PAGE_BITS'($urandom_range(16'hFFFF));
            end
            if ($urandom_range(99) < 85)
               page = working_set[$urandom_range(set_size - 1)];
            else
               page = PAGE_BITS'($urandom_range(16'hFFFF));
            eos = ($urandom_range(99) < 3);
            push_reference(page, eos);
            // start a fresh working set with each new string
            if (eos) set_size = 0;
            // let everything drain once in the middle of a phase
            if (p == 5 && i == PHASE_ITEMS / 2) drain_results();
         end
      end
      quiet = 1'b0;

      drain_results();
      repeat (FRAMES + 3) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
